@@ src/wpr_pkg.sv @@
// Package for the weighted PageRank engine: field widths, fixed-point constants,
// request, status and register codes. No dependencies.
package wpr_pkg;

    localparam int NODE_W     = 10;
    localparam int WT_W       = 16;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int RANK_W     = 32;
    localparam int ITER_W     = 10;
    localparam int NCOUNT_W   = 11;
    localparam int DAMP_W     = 16;
    localparam int EPS_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUTW_W     = 28;

    localparam logic [OUTW_W-1:0] OUTW_MAX = 28'hFFF_FFFF;
    localparam logic [RANK_W-1:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [RANK_W-1:0] RANK_SAT = 32'hFFFF_FFFF;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam logic [NCOUNT_W-1:0] RST_NODE_COUNT = 11'd1;
    localparam logic [DAMP_W-1:0]   RST_DAMPING    = 16'd55705;
    localparam logic [EPS_W-1:0]    RST_EPSILON    = 32'd214748;
    localparam logic [ITER_W-1:0]   RST_MAX_ITER   = 10'd100;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_DAMPING    = 2'd1,
        CFG_EPSILON    = 2'd2,
        CFG_MAX_ITER   = 2'd3
    } cfg_idx_t;

endpackage

@@ src/weighted_pagerank_engine_unit.sv @@
// Weighted PageRank engine, top level: edge, out-weight, rank, scratch and accumulator
// memories, a shared bit-serial divider and the request sequencer. Depends on wpr_pkg.
//
// One word in, one word out per request. After reset the out-weight and rank memories
// are wiped before the first request is taken. Clear sweeps the out-weight memory. A run
// is bounded by the divider, which retires one quotient bit a cycle (DVW bits, 48 at
// default sizes): init divides one by N and fills the rank memory, then each pass
// divides once per edge with nonzero out-weight, runs two node sweeps and divides the
// leak. Each state access is a read-modify-write through single-port-read memories,
// strictly one at a time.
module weighted_pagerank_engine_unit #(
    parameter int MAX_NODES = wpr_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = wpr_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wpr_pkg::MODE_W-1:0]        mode,
    input  logic [wpr_pkg::NODE_W-1:0]        source_node,
    input  logic [wpr_pkg::NODE_W-1:0]        target_node,
    input  logic [wpr_pkg::WT_W-1:0]          edge_weight,
    input  logic [wpr_pkg::NODE_W-1:0]        query_node,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wpr_pkg::RANK_W-1:0]        rank_value,
    output logic [wpr_pkg::ITER_W-1:0]        iterations_run,
    output logic                              converged,
    output logic [wpr_pkg::STAT_W-1:0]        status
);
    import wpr_pkg::*;

    localparam int NAW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW    = $clog2(MAX_NODES + 1);
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW    = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W = 2 * NODE_W + WT_W;
    localparam int ACCW   = RANK_W + ETW;
    localparam int MULW   = ACCW + DAMP_W;
    localparam int SUMW   = RANK_W + NCW;
    localparam int PRW    = RANK_W + WT_W;
    localparam int DVW    = (SUMW > PRW) ? SUMW : PRW;
    localparam int DCW    = $clog2(DVW + 1);

    typedef enum logic [4:0] {
        S_WIPE, S_IDLE, S_CLR, S_ADD_RD, S_ADD_WR, S_Q_RD, S_Q_OUT,
        S_R_INIT_DIV, S_R_INIT_W, S_R_INIT_FILL, S_R_PASS,
        S_R_E_CHK, S_R_E_RD, S_R_E_MUL, S_R_E_DIVS, S_R_E_DIVW, S_R_E_ACC,
        S_R_N1_RD, S_R_N1_MUL, S_R_N1_WR, S_R_LEAK, S_R_LEAK_W,
        S_R_N2_RD, S_R_N2_WR, S_R_PASS_END, S_RESP
    } state_t;

    state_t state_reg;

    // configuration
    logic [NCOUNT_W-1:0] node_count_reg;
    logic [DAMP_W-1:0]   damp_reg;
    logic [EPS_W-1:0]    eps_reg;
    logic [ITER_W-1:0]   max_iter_reg;
    logic [NCW-1:0]      n_act;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= RST_NODE_COUNT;
            damp_reg       <= RST_DAMPING;
            eps_reg        <= RST_EPSILON;
            max_iter_reg   <= RST_MAX_ITER;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NODE_COUNT: node_count_reg <= cfg_data[NCOUNT_W-1:0];
                CFG_DAMPING:    damp_reg       <= cfg_data[DAMP_W-1:0];
                CFG_EPSILON:    eps_reg        <= cfg_data[EPS_W-1:0];
                CFG_MAX_ITER:   max_iter_reg   <= cfg_data[ITER_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (node_count_reg == '0)
            n_act = NCW'(1);
        else if (32'(node_count_reg) > MAX_NODES)
            n_act = NCW'(MAX_NODES);
        else
            n_act = NCW'(node_count_reg);
    end

    // memories
    logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
    logic [OUTW_W-1:0] outw_mem [MAX_NODES];
    logic [RANK_W-1:0] rank_mem [MAX_NODES];
    logic [RANK_W-1:0] next_mem [MAX_NODES];
    logic [ACCW-1:0]   acc_mem  [MAX_NODES];

    logic              edge_we, outw_we, rank_we, next_we, acc_we;
    logic [EAW-1:0]    edge_wa, edge_ra;
    logic [NAW-1:0]    outw_wa, outw_ra, rank_wa, rank_ra, next_wa, next_ra, acc_wa, acc_ra;
    logic [EDGE_W-1:0] edge_wd;
    logic [OUTW_W-1:0] outw_wd;
    logic [RANK_W-1:0] rank_wd, next_wd;
    logic [ACCW-1:0]   acc_wd;

    logic [EDGE_W-1:0] edge_rd_reg;
    logic [OUTW_W-1:0] outw_rd_reg;
    logic [RANK_W-1:0] rank_rd_reg, next_rd_reg;
    logic [ACCW-1:0]   acc_rd_reg;

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_wa] <= edge_wd;
        edge_rd_reg <= edge_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (outw_we)
            outw_mem[outw_wa] <= outw_wd;
        outw_rd_reg <= outw_mem[outw_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_wa] <= rank_wd;
        rank_rd_reg <= rank_mem[rank_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        next_rd_reg <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_wa] <= acc_wd;
        acc_rd_reg <= acc_mem[acc_ra];
    end

    // shared restoring divider, one quotient bit per cycle
    logic              dv_start;
    logic [DVW-1:0]    dv_dividend;
    logic [OUTW_W-1:0] dv_divisor;
    logic              dv_busy_reg;
    logic [DCW-1:0]    dv_cnt_reg;
    logic [OUTW_W:0]   dv_rem_reg;
    logic [DVW-1:0]    dv_quo_reg;
    logic [OUTW_W-1:0] dv_den_reg;
    logic [OUTW_W:0]   dv_trial;
    logic              dv_ge;

    assign dv_trial = {dv_rem_reg[OUTW_W-1:0], dv_quo_reg[DVW-1]};
    assign dv_ge    = (dv_trial >= {1'b0, dv_den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else if (dv_start)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= DCW'(DVW);
        end
        else if (dv_busy_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg - DCW'(1);
            if (dv_cnt_reg == DCW'(1))
                dv_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_start)
        begin
            dv_rem_reg <= '0;
            dv_quo_reg <= dv_dividend;
            dv_den_reg <= dv_divisor;
        end
        else if (dv_busy_reg)
        begin
            dv_rem_reg <= dv_ge ? (dv_trial - {1'b0, dv_den_reg}) : dv_trial;
            dv_quo_reg <= {dv_quo_reg[DVW-2:0], dv_ge};
        end
    end

    // sequencer registers
    logic [ETW-1:0]    edge_total_reg;
    logic [ETW-1:0]    e_reg;
    logic [NCW-1:0]    idx_reg;
    logic [NODE_W-1:0] src_reg, dst_reg, q_reg;
    logic [WT_W-1:0]   win_reg;
    logic [NODE_W-1:0] to_reg;
    logic [WT_W-1:0]   wt_reg;
    logic [PRW-1:0]    prod_reg;
    logic [OUTW_W-1:0] den_reg;
    logic [MULW-1:0]   mul_reg;
    logic [RANK_W-1:0] init_reg;
    logic [SUMW-1:0]   sum_reg, diff_reg, lmag_reg;
    logic              neg_reg;
    logic [ITER_W-1:0] pass_reg;
    logic [ITER_W-1:0] last_iter_reg;
    logic              last_conv_reg;
    logic [RANK_W-1:0] res_rank_reg;
    status_t           res_status_reg;
    logic              out_valid_reg;
    logic [RANK_W-1:0] rank_value_reg;
    logic [ITER_W-1:0] iter_out_reg;
    logic              conv_out_reg;
    logic [STAT_W-1:0] status_out_reg;

    // datapath helpers
    logic [NODE_W-1:0] e_from, e_to;
    logic [WT_W-1:0]   e_wt;
    logic [OUTW_W:0]   ow_sum;
    logic [ACCW-1:0]   v_wide;
    logic [RANK_W-1:0] v_sat;
    logic [SUMW:0]     tn, lm, nv_wide;
    logic [RANK_W-1:0] nv;
    logic [RANK_W-1:0] dterm;
    logic              idx_last;
    logic              in_take;

    assign e_from = edge_rd_reg[EDGE_W-1 -: NODE_W];
    assign e_to   = edge_rd_reg[WT_W+NODE_W-1 -: NODE_W];
    assign e_wt   = edge_rd_reg[WT_W-1:0];

    assign ow_sum = {1'b0, outw_rd_reg} + (OUTW_W+1)'(win_reg);
    assign v_wide = mul_reg[MULW-1:DAMP_W];
    assign v_sat  = (v_wide > ACCW'(RANK_SAT)) ? RANK_SAT : v_wide[RANK_W-1:0];

    assign tn = (SUMW+1)'(next_rd_reg);
    assign lm = {1'b0, lmag_reg};
    always_comb
    begin
        if (neg_reg)
            nv_wide = (tn > lm) ? (tn - lm) : '0;
        else
            nv_wide = tn + lm;
        nv    = (nv_wide > (SUMW+1)'(ONE_Q31)) ? ONE_Q31 : nv_wide[RANK_W-1:0];
        dterm = (nv >= rank_rd_reg) ? (nv - rank_rd_reg) : (rank_rd_reg - nv);
    end

    assign idx_last = ((32'(idx_reg) + 32'd1) == 32'(n_act));
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    // memory and divider control
    always_comb
    begin
        edge_we = 1'b0; edge_wa = e_reg[EAW-1:0]; edge_wd = {src_reg, dst_reg, win_reg};
        edge_ra = e_reg[EAW-1:0];
        outw_we = 1'b0; outw_wa = idx_reg[NAW-1:0]; outw_wd = '0; outw_ra = NAW'(src_reg);
        rank_we = 1'b0; rank_wa = idx_reg[NAW-1:0]; rank_wd = '0; rank_ra = idx_reg[NAW-1:0];
        next_we = 1'b0; next_wa = idx_reg[NAW-1:0]; next_wd = v_sat; next_ra = idx_reg[NAW-1:0];
        acc_we  = 1'b0; acc_wa  = idx_reg[NAW-1:0]; acc_wd  = '0;    acc_ra  = idx_reg[NAW-1:0];
        dv_start    = 1'b0;
        dv_dividend = DVW'(ONE_Q31);
        dv_divisor  = OUTW_W'(n_act);
        unique case (state_reg)
            S_WIPE:
            begin
                outw_we = 1'b1;
                rank_we = 1'b1;
            end
            S_CLR:
                outw_we = 1'b1;
            S_ADD_RD:
            begin
                edge_we = 1'b1;
                edge_wa = edge_total_reg[EAW-1:0];
            end
            S_ADD_WR:
            begin
                outw_we = 1'b1;
                outw_wa = NAW'(src_reg);
                outw_wd = (ow_sum > (OUTW_W+1)'(OUTW_MAX)) ? OUTW_MAX : ow_sum[OUTW_W-1:0];
            end
            S_Q_RD:
                rank_ra = NAW'(q_reg);
            S_R_INIT_DIV:
                dv_start = 1'b1;
            S_R_INIT_FILL:
            begin
                rank_we = 1'b1;
                rank_wd = init_reg;
                acc_we  = 1'b1;
            end
            S_R_E_RD:
            begin
                outw_ra = NAW'(e_from);
                rank_ra = NAW'(e_from);
            end
            S_R_E_DIVS:
            begin
                dv_start    = 1'b1;
                dv_dividend = DVW'(prod_reg);
                dv_divisor  = den_reg;
            end
            S_R_E_DIVW:
                acc_ra = NAW'(to_reg);
            S_R_E_ACC:
            begin
                acc_we = 1'b1;
                acc_wa = NAW'(to_reg);
                acc_wd = acc_rd_reg + ACCW'(dv_quo_reg[RANK_W-1:0]);
            end
            S_R_N1_WR:
            begin
                next_we = 1'b1;
                acc_we  = 1'b1;
            end
            S_R_LEAK:
            begin
                dv_start    = 1'b1;
                dv_dividend = (sum_reg > SUMW'(ONE_Q31)) ? DVW'(sum_reg - SUMW'(ONE_Q31))
                                                         : DVW'(SUMW'(ONE_Q31) - sum_reg);
            end
            S_R_N2_WR:
            begin
                rank_we = 1'b1;
                rank_wd = nv;
            end
            default: ;
        endcase
    end

    // request sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WIPE;
            idx_reg        <= '0;
            e_reg          <= '0;
            edge_total_reg <= '0;
            pass_reg       <= '0;
            last_iter_reg  <= '0;
            last_conv_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_rank_reg   <= '0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            // S_RESP handles the output register itself
            if (out_valid_reg && !out_stall && state_reg != S_RESP)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_WIPE:
                begin
                    idx_reg <= idx_reg + NCW'(1);
                    if ((32'(idx_reg) + 32'd1) == MAX_NODES)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        src_reg        <= source_node;
                        dst_reg        <= target_node;
                        win_reg        <= edge_weight;
                        q_reg          <= query_node;
                        res_rank_reg   <= '0;
                        res_status_reg <= ST_OK;
                        unique case (mode_t'(mode))
                            MODE_CLEAR:
                            begin
                                edge_total_reg <= '0;
                                idx_reg        <= '0;
                                state_reg      <= S_CLR;
                            end
                            MODE_ADD:
                            begin
                                if (32'(source_node) >= 32'(n_act) ||
                                    32'(target_node) >= 32'(n_act))
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= S_RESP;
                                end
                                else if (32'(edge_total_reg) >= MAX_EDGES)
                                begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_RESP;
                                end
                                else
                                begin
                                    state_reg <= S_ADD_RD;
                                end
                            end
                            MODE_RUN:
                                state_reg <= S_R_INIT_DIV;
                            MODE_READ:
                            begin
                                if (32'(query_node) >= 32'(n_act))
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= S_RESP;
                                end
                                else
                                begin
                                    state_reg <= S_Q_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR:
                begin
                    idx_reg <= idx_reg + NCW'(1);
                    if ((32'(idx_reg) + 32'd1) == MAX_NODES)
                        state_reg <= S_RESP;
                end
                S_ADD_RD:
                    state_reg <= S_ADD_WR;
                S_ADD_WR:
                begin
                    edge_total_reg <= edge_total_reg + ETW'(1);
                    state_reg      <= S_RESP;
                end
                S_Q_RD:
                    state_reg <= S_Q_OUT;
                S_Q_OUT:
                begin
                    res_rank_reg <= rank_rd_reg;
                    state_reg    <= S_RESP;
                end
                S_R_INIT_DIV:
                    state_reg <= S_R_INIT_W;
                S_R_INIT_W:
                begin
                    if (!dv_busy_reg)
                    begin
                        init_reg  <= dv_quo_reg[RANK_W-1:0];
                        idx_reg   <= '0;
                        state_reg <= S_R_INIT_FILL;
                    end
                end
                S_R_INIT_FILL:
                begin
                    idx_reg <= idx_reg + NCW'(1);
                    if (idx_last)
                    begin
                        pass_reg  <= '0;
                        state_reg <= S_R_PASS;
                    end
                end
                S_R_PASS:
                begin
                    if (pass_reg >= max_iter_reg)
                    begin
                        last_iter_reg <= pass_reg;
                        last_conv_reg <= 1'b0;
                        state_reg     <= S_RESP;
                    end
                    else
                    begin
                        e_reg     <= '0;
                        state_reg <= S_R_E_CHK;
                    end
                end
                S_R_E_CHK:
                begin
                    if (e_reg == edge_total_reg)
                    begin
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_R_N1_RD;
                    end
                    else
                    begin
                        state_reg <= S_R_E_RD;
                    end
                end
                S_R_E_RD:
                begin
                    to_reg <= e_to;
                    wt_reg <= e_wt;
                    // edges left over from a larger node count are skipped
                    if (32'(e_from) >= 32'(n_act) || 32'(e_to) >= 32'(n_act))
                    begin
                        e_reg     <= e_reg + ETW'(1);
                        state_reg <= S_R_E_CHK;
                    end
                    else
                    begin
                        state_reg <= S_R_E_MUL;
                    end
                end
                S_R_E_MUL:
                begin
                    if (outw_rd_reg == '0)
                    begin
                        e_reg     <= e_reg + ETW'(1);
                        state_reg <= S_R_E_CHK;
                    end
                    else
                    begin
                        prod_reg  <= PRW'(rank_rd_reg) * PRW'(wt_reg);
                        den_reg   <= outw_rd_reg;
                        state_reg <= S_R_E_DIVS;
                    end
                end
                S_R_E_DIVS:
                    state_reg <= S_R_E_DIVW;
                S_R_E_DIVW:
                begin
                    if (!dv_busy_reg)
                        state_reg <= S_R_E_ACC;
                end
                S_R_E_ACC:
                begin
                    e_reg     <= e_reg + ETW'(1);
                    state_reg <= S_R_E_CHK;
                end
                S_R_N1_RD:
                    state_reg <= S_R_N1_MUL;
                S_R_N1_MUL:
                begin
                    mul_reg   <= MULW'(acc_rd_reg) * MULW'(damp_reg);
                    state_reg <= S_R_N1_WR;
                end
                S_R_N1_WR:
                begin
                    sum_reg <= sum_reg + SUMW'(v_sat);
                    idx_reg <= idx_reg + NCW'(1);
                    if (idx_last)
                        state_reg <= S_R_LEAK;
                    else
                        state_reg <= S_R_N1_RD;
                end
                S_R_LEAK:
                begin
                    neg_reg   <= (sum_reg > SUMW'(ONE_Q31));
                    state_reg <= S_R_LEAK_W;
                end
                S_R_LEAK_W:
                begin
                    if (!dv_busy_reg)
                    begin
                        lmag_reg  <= dv_quo_reg[SUMW-1:0];
                        idx_reg   <= '0;
                        diff_reg  <= '0;
                        state_reg <= S_R_N2_RD;
                    end
                end
                S_R_N2_RD:
                    state_reg <= S_R_N2_WR;
                S_R_N2_WR:
                begin
                    diff_reg <= diff_reg + SUMW'(dterm);
                    idx_reg  <= idx_reg + NCW'(1);
                    if (idx_last)
                        state_reg <= S_R_PASS_END;
                    else
                        state_reg <= S_R_N2_RD;
                end
                S_R_PASS_END:
                begin
                    pass_reg <= pass_reg + ITER_W'(1);
                    if (diff_reg < SUMW'(eps_reg))
                    begin
                        last_iter_reg <= pass_reg + ITER_W'(1);
                        last_conv_reg <= 1'b1;
                        state_reg     <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_R_PASS;
                    end
                end
                S_RESP:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        rank_value_reg <= res_rank_reg;
                        iter_out_reg   <= last_iter_reg;
                        conv_out_reg   <= last_conv_reg;
                        status_out_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign rank_value     = rank_value_reg;
    assign iterations_run = iter_out_reg;
    assign converged      = conv_out_reg;
    assign status         = status_out_reg;

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_total_reg) <= MAX_EDGES)
        else $error("edge count beyond store depth");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dv_start |-> !dv_busy_reg)
        else $error("divider restarted while busy");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R_N2_WR) |-> (rank_wd <= ONE_Q31))
        else $error("rank written above one");

endmodule
